[rtl/rcm_pkg.sv]
// Shared types, constants and register map of the RC capacitance meter.
package rcm_pkg;

  // Field widths.
  localparam int unsigned SampleW = 12;
  localparam int unsigned TickW   = 20;
  localparam int unsigned SettleW = 10;
  localparam int unsigned CapW    = 30;
  localparam int unsigned DriveW  = 2;

  // Configuration port geometry.
  localparam int unsigned AddrW   = 5;
  localparam int unsigned DataW   = 32;
  localparam int unsigned IndexW  = 3;

  // Register indexes.
  localparam logic [IndexW-1:0] REG_THRESHOLD  = 3'd0;
  localparam logic [IndexW-1:0] REG_TIMEOUT    = 3'd1;
  localparam logic [IndexW-1:0] REG_DISCHARGE  = 3'd2;
  localparam logic [IndexW-1:0] REG_SETTLE     = 3'd3;
  localparam logic [IndexW-1:0] REG_PAR_HIGH   = 3'd4;
  localparam logic [IndexW-1:0] REG_PAR_LOW    = 3'd5;
  localparam logic [IndexW-1:0] REG_RANGE_LIM  = 3'd6;

  // Register reset values.
  localparam logic [SampleW-1:0] THRESHOLD_RST = 12'd2588;
  localparam logic [TickW-1:0]   TIMEOUT_RST   = 20'd500000;
  localparam logic [TickW-1:0]   DISCHARGE_RST = 20'd50000;
  localparam logic [SettleW-1:0] SETTLE_RST    = 10'd10;
  localparam logic [TickW-1:0]   PAR_HIGH_RST  = 20'd300;
  localparam logic [TickW-1:0]   PAR_LOW_RST   = 20'd0;
  localparam logic [TickW-1:0]   RANGE_LIM_RST = 20'd1000000;

  // One tick on the 1k range is worth this many picofarads.
  localparam logic [CapW-1:0] LOW_RANGE_SCALE = 30'd1000;

  // Pin drive codes.
  localparam logic [DriveW-1:0] DRV_HIZ  = 2'd0;
  localparam logic [DriveW-1:0] DRV_LOW  = 2'd1;
  localparam logic [DriveW-1:0] DRV_HIGH = 2'd2;

  typedef enum logic [1:0] {
    PH_IDLE      = 2'd0,
    PH_DISCHARGE = 2'd1,
    PH_SETTLE    = 2'd2,
    PH_CHARGE    = 2'd3
  } phase_t;

  // Current configuration as seen by the measurement core.
  typedef struct packed {
    logic [SampleW-1:0] threshold_level;
    logic [TickW-1:0]   timeout_ticks;
    logic [TickW-1:0]   discharge_ticks;
    logic [SettleW-1:0] settle_ticks;
    logic [TickW-1:0]   parasitic_high_pf;
    logic [TickW-1:0]   parasitic_low_pf;
    logic [TickW-1:0]   range_limit_pf;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic              discharge_on;
    logic [DriveW-1:0] high_r_drive;
    logic [DriveW-1:0] low_r_drive;
    logic              busy_res;
    logic              done_res;
    logic              open_circuit;
    logic              used_low_range;
    logic [CapW-1:0]   capacitance_pf;
  } res_t;

endpackage

[rtl/rcm_regs.sv]
// Configuration register file behind the APB-style port.
module rcm_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [rcm_pkg::AddrW-1:0]   paddr,
  input  logic [rcm_pkg::DataW-1:0]   pwdata,
  output logic [rcm_pkg::DataW-1:0]   prdata,
  output logic                        pready,
  output rcm_pkg::cfg_t               cfg
);
  import rcm_pkg::*;

  logic [IndexW-1:0] index;
  logic              wr_en;

  assign index  = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes; an index beyond the map is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.threshold_level   <= THRESHOLD_RST;
      cfg.timeout_ticks     <= TIMEOUT_RST;
      cfg.discharge_ticks   <= DISCHARGE_RST;
      cfg.settle_ticks      <= SETTLE_RST;
      cfg.parasitic_high_pf <= PAR_HIGH_RST;
      cfg.parasitic_low_pf  <= PAR_LOW_RST;
      cfg.range_limit_pf    <= RANGE_LIM_RST;
    end else if (wr_en) begin
      unique case (index)
        REG_THRESHOLD: cfg.threshold_level   <= pwdata[SampleW-1:0];
        REG_TIMEOUT:   cfg.timeout_ticks     <= pwdata[TickW-1:0];
        REG_DISCHARGE: cfg.discharge_ticks   <= pwdata[TickW-1:0];
        REG_SETTLE:    cfg.settle_ticks      <= pwdata[SettleW-1:0];
        REG_PAR_HIGH:  cfg.parasitic_high_pf <= pwdata[TickW-1:0];
        REG_PAR_LOW:   cfg.parasitic_low_pf  <= pwdata[TickW-1:0];
        REG_RANGE_LIM: cfg.range_limit_pf    <= pwdata[TickW-1:0];
        default: ;
      endcase
    end
  end

  // Read decode.
  always_comb begin
    unique case (index)
      REG_THRESHOLD: prdata = DataW'(cfg.threshold_level);
      REG_TIMEOUT:   prdata = DataW'(cfg.timeout_ticks);
      REG_DISCHARGE: prdata = DataW'(cfg.discharge_ticks);
      REG_SETTLE:    prdata = DataW'(cfg.settle_ticks);
      REG_PAR_HIGH:  prdata = DataW'(cfg.parasitic_high_pf);
      REG_PAR_LOW:   prdata = DataW'(cfg.parasitic_low_pf);
      REG_RANGE_LIM: prdata = DataW'(cfg.range_limit_pf);
      default:       prdata = '0;
    endcase
  end

endmodule

[rtl/rcm_core.sv]
// Measurement sequencer: phase, range and tick counter, and the reading arithmetic.
module rcm_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic                          start_request,
  input  logic [rcm_pkg::SampleW-1:0]   adc_sample,
  input  rcm_pkg::cfg_t                 cfg,
  output rcm_pkg::res_t                 res
);
  import rcm_pkg::*;

  phase_t           phase, phase_next;
  logic             range_flag, range_flag_next;
  logic [TickW-1:0] tick_count, tick_count_next;

  logic             done, open_ckt, used_low;
  logic [CapW-1:0]  cap;
  logic [TickW:0]   tick_inc;
  logic [CapW-1:0]  low_product;
  logic [CapW-1:0]  low_reading;
  logic [TickW-1:0] high_reading;
  logic [DriveW-1:0] drive;

  assign tick_inc = {1'b0, tick_count} + 21'd1;

  // Readings for both ranges; the low range scales ticks to picofarads.
  assign low_product  = CapW'(tick_count) * LOW_RANGE_SCALE;
  assign low_reading  = (low_product > CapW'(cfg.parasitic_low_pf)) ?
                        low_product - CapW'(cfg.parasitic_low_pf) : '0;
  assign high_reading = (tick_count > cfg.parasitic_high_pf) ?
                        tick_count - cfg.parasitic_high_pf : '0;

  // Next state and completion.
  always_comb begin
    phase_next      = phase;
    range_flag_next = range_flag;
    tick_count_next = tick_count;
    done            = 1'b0;
    open_ckt        = 1'b0;
    used_low        = 1'b0;
    cap             = '0;
    unique case (phase)
      PH_IDLE: begin
        if (start_request) begin
          phase_next      = PH_DISCHARGE;
          range_flag_next = 1'b0;
          tick_count_next = '0;
        end
      end
      PH_DISCHARGE: begin
        if (tick_inc >= {1'b0, cfg.discharge_ticks}) begin
          tick_count_next = '0;
          phase_next      = (cfg.settle_ticks == '0) ? PH_CHARGE : PH_SETTLE;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_SETTLE: begin
        if (tick_inc >= (TickW+1)'(cfg.settle_ticks)) begin
          phase_next      = PH_CHARGE;
          tick_count_next = '0;
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
      end
      PH_CHARGE: begin
        if (adc_sample >= cfg.threshold_level) begin
          if (!range_flag) begin
            if (tick_count <= cfg.range_limit_pf) begin
              done = 1'b1;
              cap  = CapW'(high_reading);
            end else begin
              // Reading too large for the 1M range: retry on 1k.
              phase_next      = PH_DISCHARGE;
              range_flag_next = 1'b1;
              tick_count_next = '0;
            end
          end else begin
            done     = 1'b1;
            used_low = 1'b1;
            cap      = low_reading;
          end
        end else if (tick_count >= cfg.timeout_ticks) begin
          if (!range_flag) begin
            phase_next      = PH_DISCHARGE;
            range_flag_next = 1'b1;
            tick_count_next = '0;
          end else begin
            done     = 1'b1;
            open_ckt = 1'b1;
          end
        end else begin
          tick_count_next = tick_inc[TickW-1:0];
        end
        if (done) begin
          phase_next      = PH_IDLE;
          range_flag_next = 1'b0;
          tick_count_next = '0;
        end
      end
      default: ;
    endcase
  end

  // Pin states and status follow the state after this tick.
  always_comb begin
    unique case (phase_next)
      PH_DISCHARGE: drive = DRV_LOW;
      PH_SETTLE:    drive = DRV_LOW;
      PH_CHARGE:    drive = DRV_HIGH;
      default:      drive = DRV_HIZ;
    endcase
    res.discharge_on   = (phase_next == PH_DISCHARGE);
    res.high_r_drive   = range_flag_next ? DRV_HIZ : drive;
    res.low_r_drive    = range_flag_next ? drive : DRV_HIZ;
    res.busy_res       = (phase_next != PH_IDLE);
    res.done_res       = done;
    res.open_circuit   = open_ckt;
    res.used_low_range = used_low;
    res.capacitance_pf = cap;
  end

  // State registers advance once per tick item.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      range_flag <= 1'b0;
      tick_count <= '0;
    end else if (step) begin
      phase      <= phase_next;
      range_flag <= range_flag_next;
      tick_count <= tick_count_next;
    end
  end

endmodule

[rtl/rc_capacitance_autorange_meter.sv]
// Top level of the two-range RC time-constant capacitance meter.
//
//   Port group   Direction  Handshake            Payload
//   input tick   in         in_valid/in_ready    start_request, adc_sample
//   result       out        out_valid/out_ready  pins, status, capacitance_pf
//   config       in         APB psel/penable     paddr, pwdata / prdata
//
// One tick item is taken per cycle while in_ready is high. The input register
// takes an item at the transfer and the result register takes its result when
// the staged item moves on, with the sequencer updated on the way. Reset clears
// both valid bits and the sequencer, and restores every configuration register.
// When out_ready is low with a result held, the result register holds, the
// input register fills, then in_ready drops.
module rc_capacitance_autorange_meter (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          start_request,
  input  logic [rcm_pkg::SampleW-1:0]   adc_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          discharge_on,
  output logic [rcm_pkg::DriveW-1:0]    high_r_drive,
  output logic [rcm_pkg::DriveW-1:0]    low_r_drive,
  output logic                          busy_res,
  output logic                          done_res,
  output logic                          open_circuit,
  output logic                          used_low_range,
  output logic [rcm_pkg::CapW-1:0]      capacitance_pf,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rcm_pkg::AddrW-1:0]     paddr,
  input  logic [rcm_pkg::DataW-1:0]     pwdata,
  output logic [rcm_pkg::DataW-1:0]     prdata,
  output logic                          pready
);
  import rcm_pkg::*;

  cfg_t               cfg;
  res_t               res_comb;
  res_t               res_reg;
  logic               stage_valid;
  logic               stage_start;
  logic [SampleW-1:0] stage_sample;
  logic               stage_move;

  // The staged tick moves on whenever the result register is free or emptying.
  assign stage_move = stage_valid & (~out_valid | out_ready);
  assign in_ready   = ~stage_valid | stage_move;

  rcm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rcm_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (stage_move),
    .start_request (stage_start),
    .adc_sample    (stage_sample),
    .cfg           (cfg),
    .res           (res_comb)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_start  <= start_request;
      stage_sample <= adc_sample;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stage_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      res_reg <= res_comb;
    end
  end

  assign discharge_on   = res_reg.discharge_on;
  assign high_r_drive   = res_reg.high_r_drive;
  assign low_r_drive    = res_reg.low_r_drive;
  assign busy_res       = res_reg.busy_res;
  assign done_res       = res_reg.done_res;
  assign open_circuit   = res_reg.open_circuit;
  assign used_low_range = res_reg.used_low_range;
  assign capacitance_pf = res_reg.capacitance_pf;

endmodule
